@@ hdl/pso_pkg.sv @@
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, sizes and codes of the periodic stencil operator.
// ----------------------------------------------------------------------------
package pso_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLS    = 32;
    localparam int VALUE_WIDTH = 24;

    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int SIZE_W    = 6;
    localparam int MU_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int OUT_W     = 48;
    localparam int STAT_W    = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MU_ROW    = 2'd0,
        CFG_MU_COL    = 2'd1,
        CFG_ROWS_USED = 2'd2,
        CFG_COLS_USED = 2'd3
    } t_cfg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_C,
        S_RD_U,
        S_RD_D,
        S_RD_R,
        S_RD_L,
        S_MUL_R,
        S_MUL_C,
        S_SUM,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        NB_C,
        NB_U,
        NB_D,
        NB_R,
        NB_L
    } t_nbr;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_V,
        CAP_DR0,
        CAP_DR1,
        CAP_DC0,
        CAP_DC1
    } t_cap;

    typedef struct packed {
        logic in_take;
        logic rd_en;
        t_nbr rd_sel;
        t_cap cap;
        logic mul_en;
        logic mul_col;
        logic sum_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic outside;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/pso_ctrl.sv @@
// ----------------------------------------------------------------------------
// pso_ctrl
// Sequencer: takes transactions, steps the five grid reads, the multiplier
// passes, the final add and the result load.
// ----------------------------------------------------------------------------
module pso_ctrl
    import pso_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_op,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign o_stall = (r_state != S_IDLE);
    assign w_take  = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take && i_op == OP_APPLY) n_state = S_RD_C;
            end
            S_RD_C: begin
                n_state = i_stat.outside ? S_DONE : S_RD_U;
            end
            S_RD_U:  n_state = S_RD_D;
            S_RD_D:  n_state = S_RD_R;
            S_RD_R:  n_state = S_RD_L;
            S_RD_L:  n_state = S_MUL_R;
            S_MUL_R: n_state = S_MUL_C;
            S_MUL_C: n_state = S_SUM;
            S_SUM:   n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_sel  = NB_C;
        o_cmd.cap     = CAP_NONE;
        o_cmd.in_take = w_take;
        case (r_state)
            S_RD_C: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = NB_C;
            end
            S_RD_U: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = NB_U;
                o_cmd.cap    = CAP_V;
            end
            S_RD_D: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = NB_D;
                o_cmd.cap    = CAP_DR0;
            end
            S_RD_R: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = NB_R;
                o_cmd.cap    = CAP_DR1;
            end
            S_RD_L: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = NB_L;
                o_cmd.cap    = CAP_DC0;
            end
            S_MUL_R: begin
                o_cmd.cap     = CAP_DC1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_col = 1'b0;
            end
            S_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_col = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.in_take = w_take;
            end
        endcase
    end

    a_apply_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == OP_APPLY) |=> (r_state == S_RD_C))
        else $error("apply transaction did not start the read sequence");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == OP_WRITE) |=> (r_state == S_IDLE))
        else $error("write transaction left the sequencer busy");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_stat.out_free) |=> (r_state == S_DONE))
        else $error("pending result dropped while the output was busy");

endmodule

@@ hdl/pso_dp.sv @@
// ----------------------------------------------------------------------------
// pso_dp
// Datapath: configuration registers, grid memory, neighbor addressing,
// shared multiplier, accumulation, saturation and the result register.
// ----------------------------------------------------------------------------
module pso_dp
    import pso_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_op,
    input  logic [ROW_W-1:0]              i_row,
    input  logic [COL_W-1:0]              i_col,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_stall,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    output logic                          o_valid,
    output logic signed [OUT_W-1:0]       o_applied,
    output logic [STAT_W-1:0]             o_status
);

    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int D_W       = VALUE_WIDTH + 2;
    localparam int P_W       = MU_W + 1 + D_W;
    localparam int T_W       = P_W + 2;
    localparam int FRAC      = 16;
    localparam logic [FRAC-1:0] ROUND_HALF = 16'h8000;
    localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_8000_0000_0000;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n,
                                                   input int maxn);
        logic [SIZE_W-1:0] r;
        if (n == '0) begin
            r = SIZE_W'(1);
        end else if (int'(n) > maxn) begin
            r = SIZE_W'(maxn);
        end else begin
            r = n;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

    logic [MU_W-1:0]   r_mu_row;
    logic [MU_W-1:0]   r_mu_col;
    logic [SIZE_W-1:0] r_rows_used;
    logic [SIZE_W-1:0] r_cols_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_row    <= MU_W'(65536);
            r_mu_col    <= MU_W'(65536);
            r_rows_used <= SIZE_W'(32);
            r_cols_used <= SIZE_W'(32);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MU_ROW:    r_mu_row    <= i_cfg_data[MU_W-1:0];
                CFG_MU_COL:    r_mu_col    <= i_cfg_data[MU_W-1:0];
                CFG_ROWS_USED: r_rows_used <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS_USED: r_cols_used <= i_cfg_data[SIZE_W-1:0];
                default:       r_mu_row    <= r_mu_row;
            endcase
        end
    end

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_row <= i_row;
            r_col <= i_col;
        end
    end

    logic [SIZE_W-1:0] w_nr;
    logic [SIZE_W-1:0] w_nc;
    logic [SIZE_W-1:0] w_r;
    logic [SIZE_W-1:0] w_c;
    logic [SIZE_W-1:0] w_up;
    logic [SIZE_W-1:0] w_dn;
    logic [SIZE_W-1:0] w_rt;
    logic [SIZE_W-1:0] w_lf;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we;

    assign w_nr = eff_size(r_rows_used, MAX_ROWS);
    assign w_nc = eff_size(r_cols_used, MAX_COLS);
    assign w_r  = SIZE_W'(r_row);
    assign w_c  = SIZE_W'(r_col);
    assign w_up = (w_r + SIZE_W'(1) == w_nr) ? '0 : w_r + SIZE_W'(1);
    assign w_dn = (w_r == '0) ? w_nr - SIZE_W'(1) : w_r - SIZE_W'(1);
    assign w_rt = (w_c + SIZE_W'(1) == w_nc) ? '0 : w_c + SIZE_W'(1);
    assign w_lf = (w_c == '0) ? w_nc - SIZE_W'(1) : w_c - SIZE_W'(1);

    assign o_stat.outside = (w_r >= w_nr) || (w_c >= w_nc);

    always_comb begin
        case (i_cmd.rd_sel)
            NB_C:    w_rd_addr = addr_of(w_r, w_c);
            NB_U:    w_rd_addr = addr_of(w_up, w_c);
            NB_D:    w_rd_addr = addr_of(w_dn, w_c);
            NB_R:    w_rd_addr = addr_of(w_r, w_rt);
            NB_L:    w_rd_addr = addr_of(w_r, w_lf);
            default: w_rd_addr = addr_of(w_r, w_c);
        endcase
    end

    assign w_we = i_cmd.in_take && (i_op == OP_WRITE) &&
                  (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign w_addr = w_we ? addr_of(SIZE_W'(i_row), SIZE_W'(i_col)) : w_rd_addr;

    logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= i_value;
        end else if (i_cmd.rd_en) begin
            r_rdata <= mem[w_addr];
        end
    end

    logic signed [VALUE_WIDTH-1:0] r_v;
    logic signed [D_W-1:0]         r_dr;
    logic signed [D_W-1:0]         r_dc;
    logic signed [D_W-1:0]         w_rd_ext;
    logic signed [D_W-1:0]         w_v2;

    assign w_rd_ext = D_W'($signed(r_rdata));
    assign w_v2     = D_W'(r_v) <<< 1;

    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            CAP_V:   r_v  <= $signed(r_rdata);
            CAP_DR0: r_dr <= w_v2 - w_rd_ext;
            CAP_DR1: r_dr <= r_dr - w_rd_ext;
            CAP_DC0: r_dc <= w_v2 - w_rd_ext;
            CAP_DC1: r_dc <= r_dc - w_rd_ext;
            default: r_v  <= r_v;
        endcase
    end

    logic signed [MU_W:0]  w_mul_a;
    logic signed [D_W-1:0] w_mul_b;
    logic signed [P_W-1:0] w_prod;
    logic signed [P_W-1:0] r_pr;
    logic signed [P_W-1:0] r_pc;
    logic signed [T_W-1:0] r_acc;
    logic signed [T_W-1:0] r_total;

    assign w_mul_a = $signed({1'b0, (i_cmd.mul_col ? r_mu_col : r_mu_row)});
    assign w_mul_b = i_cmd.mul_col ? r_dc : r_dr;
    assign w_prod  = P_W'(w_mul_a) * P_W'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_col) begin
                r_pc  <= w_prod;
                r_acc <= T_W'($signed({r_v, ROUND_HALF})) + T_W'(r_pr);
            end else begin
                r_pr <= w_prod;
            end
        end
        if (i_cmd.sum_en) begin
            r_total <= r_acc + T_W'(r_pc);
        end
    end

    logic signed [63:0] w_res;
    logic signed [OUT_W-1:0] w_applied;
    t_status w_status;

    assign w_res = 64'(r_total >>> FRAC);

    always_comb begin
        if (o_stat.outside) begin
            w_applied = '0;
            w_status  = ST_OUTSIDE;
        end else if (w_res > SAT_HI) begin
            w_applied = OUT_W'(SAT_HI);
            w_status  = ST_SAT;
        end else if (w_res < SAT_LO) begin
            w_applied = OUT_W'(SAT_LO);
            w_status  = ST_SAT;
        end else begin
            w_applied = OUT_W'(w_res);
            w_status  = ST_OK;
        end
    end

    logic r_out_valid;

    assign o_valid         = r_out_valid;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_applied <= w_applied;
            o_status  <= w_status;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_out_valid) |-> !i_stall)
        else $error("result register overwritten while stalled");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |->
        (o_applied == OUT_W'(SAT_HI) || o_applied == OUT_W'(SAT_LO)))
        else $error("saturated result not at a bound");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OUTSIDE) |-> (o_applied == '0))
        else $error("outside result not zero");

endmodule

@@ hdl/periodic_stencil_operator.sv @@
// ----------------------------------------------------------------------------
// periodic_stencil_operator
// Five-point periodic implicit-Euler stencil over a 32x32 grid store.
//
//   channel  direction  handshake                 payload
//   input    in         i_valid / o_stall         i_op, i_row, i_col, i_value
//   result   out        o_valid / i_stall         o_applied, o_status
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A write is stored as it is taken. An apply transaction makes five reads
// through the single grid memory port, two passes through the shared multiplier,
// one add and the result load; outside the grid, only the center read and the load.
// Synchronous active-low reset restores the coupling and size registers;
// the grid store holds no reset and needs no clearing pass.
// The result register frees the input side: a new transaction is taken
// while a result waits; a stalled result holds the next apply at its end.
// ----------------------------------------------------------------------------
module periodic_stencil_operator
    import pso_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [ROW_W-1:0]              i_row,
    input  logic [COL_W-1:0]              i_col,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_applied,
    output logic [STAT_W-1:0]             o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    pso_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    pso_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_applied   (o_applied),
        .o_status    (o_status)
    );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic five-point stencil operator. A short
// table of directed transactions covers extreme values, both operations,
// zero and oversized grid sizes and out-of-grid indexes. Random phases follow
// under random register settings, with the sender idling in bursts and the
// receiver stalling on its own pattern, once for a long stretch. Every result is
// checked against a scripted value or a bench model of grid store and operator.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pso_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 9;
    localparam int PHASE_ITEMS     = 150;
    localparam int MAX_REPORTS     = 10;
    localparam int GRID_DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int DIRECTED_N      = 35;

    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic signed [OUT_W-1:0] applied;
        t_status                 status;
    } t_result;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_WRITE,
        STEP_APPLY
    } t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        t_cfg_idx                idx;
        logic [CFG_W-1:0]        data;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [VALUE_WIDTH-1:0]  value;
        logic                    typed;
        t_result                 want;
    } t_step;

    localparam t_result EXP_NONE    = '{48'sd0, ST_OK};
    localparam t_result EXP_TOP     = '{48'sd8388607, ST_OK};
    localparam t_result EXP_BOTTOM  = '{-48'sd8388608, ST_OK};
    localparam t_result EXP_OUTSIDE = '{48'sd0, ST_OUTSIDE};

    localparam t_step SCRIPT [DIRECTED_N] = '{
        '{STEP_CFG,   CFG_ROWS_USED, 32'd1,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_COLS_USED, 32'd1,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h7FFFFF, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b1, EXP_TOP},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h800000, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h5A5A5A, 1'b1, EXP_BOTTOM},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd1,  24'h000000, 1'b1, EXP_OUTSIDE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'hFFFFFF, 1'b1, EXP_OUTSIDE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'h123456, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_ROWS_USED, 32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd1,  5'd0,  24'h000000, 1'b1, EXP_OUTSIDE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b1, EXP_BOTTOM},
        '{STEP_CFG,   CFG_ROWS_USED, 32'd63,        5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_COLS_USED, 32'd32,        5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_ROW,    32'hFFFFFFFF,  5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_COL,    32'hFFFFFFFF,  5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd0,  5'd31, 24'h800000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd30, 5'd31, 24'h800000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd31, 5'd0,  24'h800000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd31, 5'd30, 24'h800000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'h7FFFFF, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_COL,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'h000000, 1'b1, EXP_TOP},
        '{STEP_CFG,   CFG_MU_ROW,    32'h00008000,  5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd31, 5'd31, 24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_ROW,    32'h00010000,  5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_MU_COL,    32'h00010000,  5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd1,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_WRITE, CFG_MU_ROW,    32'd0,         5'd0,  5'd1,  24'h000001, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_CFG,   CFG_COLS_USED, 32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd5,  24'h000000, 1'b1, EXP_OUTSIDE},
        '{STEP_APPLY, CFG_MU_ROW,    32'd0,         5'd0,  5'd0,  24'h000000, 1'b0, EXP_NONE}
    };

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic                          i_op        = OP_WRITE;
    logic [ROW_W-1:0]              i_row       = '0;
    logic [COL_W-1:0]              i_col       = '0;
    logic signed [VALUE_WIDTH-1:0] i_value     = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic signed [OUT_W-1:0]       o_applied;
    logic [STAT_W-1:0]             o_status;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]              i_cfg_data  = '0;

    logic signed [VALUE_WIDTH-1:0] grid_model [GRID_DEPTH];
    bit                            grid_written [GRID_DEPTH];
    logic [MU_W-1:0]               mu_row_q  = 32'h0001_0000;
    logic [MU_W-1:0]               mu_col_q  = 32'h0001_0000;
    logic [SIZE_W-1:0]             rows_q    = 6'd32;
    logic [SIZE_W-1:0]             cols_q    = 6'd32;

    t_result stencil_due [$];
    int      mismatches    = 0;
    int      idle_cycles   = 0;
    bit      hold_off_req  = 1'b0;

    periodic_stencil_operator dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int eff_extent(input logic [SIZE_W-1:0] size, input int limit);
        if (size == 0) return 1;
        if (int'(size) > limit) return limit;
        return int'(size);
    endfunction

    // center, up, down, right, left
    function automatic void stencil_taps(input int r, input int c, input int nr,
                                         input int nc, output int addr [5]);
        int up;
        int dn;
        int rt;
        int lf;
        up = (r + 1 == nr) ? 0 : r + 1;
        dn = (r == 0) ? nr - 1 : r - 1;
        rt = (c + 1 == nc) ? 0 : c + 1;
        lf = (c == 0) ? nc - 1 : c - 1;
        addr[0] = r * MAX_COLS + c;
        addr[1] = up * MAX_COLS + c;
        addr[2] = dn * MAX_COLS + c;
        addr[3] = r * MAX_COLS + rt;
        addr[4] = r * MAX_COLS + lf;
    endfunction

    function automatic t_result stencil_value(input int r, input int c);
        t_result res;
        int      nr;
        int      nc;
        int      addr [5];
        longint  v;
        longint  dr;
        longint  dc;
        longint  mr_hi;
        longint  mr_lo;
        longint  mc_hi;
        longint  mc_lo;
        longint  hi;
        longint  lo;
        longint  total;
        nr = eff_extent(rows_q, MAX_ROWS);
        nc = eff_extent(cols_q, MAX_COLS);
        if (r >= nr || c >= nc) begin
            res.applied = '0;
            res.status  = ST_OUTSIDE;
            return res;
        end
        stencil_taps(r, c, nr, nc, addr);
        v     = longint'(grid_model[addr[0]]);
        dr    = 2 * v - grid_model[addr[1]] - grid_model[addr[2]];
        dc    = 2 * v - grid_model[addr[3]] - grid_model[addr[4]];
        mr_hi = longint'(mu_row_q[31:16]);
        mr_lo = longint'(mu_row_q[15:0]);
        mc_hi = longint'(mu_col_q[31:16]);
        mc_lo = longint'(mu_col_q[15:0]);
        hi    = v + mr_hi * dr + mc_hi * dc;
        lo    = mr_lo * dr + mc_lo * dc;
        total = hi + ((lo + 64'sd32768) >>> 16);
        res.status = ST_OK;
        if (total > SAT_HI) begin
            total      = SAT_HI;
            res.status = ST_SAT;
        end else if (total < SAT_LO) begin
            total      = SAT_LO;
            res.status = ST_SAT;
        end
        res.applied = total[OUT_W-1:0];
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return SIZE_W'($urandom_range(33, 63));
            default: return SIZE_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [MU_W-1:0] pick_mu();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    task automatic pause(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (stencil_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MU_ROW:    mu_row_q = data;
            CFG_MU_COL:    mu_col_q = data;
            CFG_ROWS_USED: rows_q   = data[SIZE_W-1:0];
            CFG_COLS_USED: cols_q   = data[SIZE_W-1:0];
            default:       ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic offer(input logic op, input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                         input logic [VALUE_WIDTH-1:0] v, input logic typed,
                         input t_result want);
        i_valid <= 1'b1;
        i_op    <= op;
        i_row   <= r;
        i_col   <= c;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_WRITE) begin
            grid_model[r * MAX_COLS + c]   = v;
            grid_written[r * MAX_COLS + c] = 1'b1;
        end else begin
            stencil_due.push_back(typed ? want : stencil_value(r, c));
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (stencil_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: applied %0d status %0d", o_applied, o_status);
            end else begin
                want = stencil_due.pop_front();
                if (o_applied !== want.applied || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: applied %0d status %0d, expected %0d status %0d",
                                 o_applied, o_status, want.applied, want.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("periodic_stencil_operator regression: fail");
            $finish;
        end
    end

    initial begin
        int mode;
        int span;
        int beat;
        beat = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(posedge i_clk);
                beat++;
                if (hold_off_req) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                    hold_off_req = 1'b0;
                end
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (beat % 3 == 2);
                endcase
            end
        end
    end

    initial begin
        int                     nr;
        int                     nc;
        int                     pick;
        int                     burst_left;
        int                     addr [5];
        logic                   op;
        logic [ROW_W-1:0]       r;
        logic [COL_W-1:0]       c;
        logic [VALUE_WIDTH-1:0] v;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_N; k++) begin
            if (SCRIPT[k].kind == STEP_CFG) begin
                settle();
                write_reg(SCRIPT[k].idx, SCRIPT[k].data);
            end else begin
                offer((SCRIPT[k].kind == STEP_APPLY) ? OP_APPLY : OP_WRITE,
                      SCRIPT[k].row, SCRIPT[k].col, SCRIPT[k].value,
                      SCRIPT[k].typed, SCRIPT[k].want);
                if ($urandom_range(0, 1) == 0)
                    pause($urandom_range(1, 3));
            end
        end

        burst_left = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            write_reg(CFG_MU_ROW, pick_mu());
            write_reg(CFG_MU_COL, pick_mu());
            write_reg(CFG_ROWS_USED, {{(CFG_W-SIZE_W){1'b0}}, pick_extent()});
            write_reg(CFG_COLS_USED, {{(CFG_W-SIZE_W){1'b0}}, pick_extent()});
            nr = eff_extent(rows_q, MAX_ROWS);
            nc = eff_extent(cols_q, MAX_COLS);
            if (phase == 0)
                hold_off_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                op   = OP_APPLY;
                case ($urandom_range(0, 7))
                    0:       v = 24'h7FFFFF;
                    1:       v = 24'h800000;
                    2:       v = '0;
                    default: v = VALUE_WIDTH'($urandom);
                endcase
                if (pick < 10 && (nr < MAX_ROWS || nc < MAX_COLS)) begin
                    if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1) == 0)) begin
                        r = ROW_W'($urandom_range(nr, MAX_ROWS - 1));
                        c = COL_W'($urandom_range(0, MAX_COLS - 1));
                    end else begin
                        r = ROW_W'($urandom_range(0, MAX_ROWS - 1));
                        c = COL_W'($urandom_range(nc, MAX_COLS - 1));
                    end
                end else if (pick < 40) begin
                    op = OP_WRITE;
                    if (pick < 34) begin
                        r = ROW_W'($urandom_range(0, nr - 1));
                        c = COL_W'($urandom_range(0, nc - 1));
                    end else begin
                        r = ROW_W'($urandom_range(0, MAX_ROWS - 1));
                        c = COL_W'($urandom_range(0, MAX_COLS - 1));
                    end
                end else begin
                    r = ROW_W'($urandom_range(0, nr - 1));
                    c = COL_W'($urandom_range(0, nc - 1));
                    stencil_taps(r, c, nr, nc, addr);
                    // fill an unwritten tap first
                    foreach (addr[t]) begin
                        if (!grid_written[addr[t]]) begin
                            op = OP_WRITE;
                            r  = ROW_W'(addr[t] / MAX_COLS);
                            c  = COL_W'(addr[t] % MAX_COLS);
                            break;
                        end
                    end
                end
                offer(op, r, c, v, 1'b0, EXP_NONE);
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 12);
                    pause($urandom_range(1, 8));
                end else begin
                    burst_left--;
                end
            end
        end

        settle();
        if (mismatches == 0 && stencil_due.size() == 0) begin
            $display("periodic_stencil_operator regression: pass");
        end else begin
            $display("periodic_stencil_operator regression: fail");
        end
        $finish;
    end

endmodule
